// ===== src/crc_pkg.sv =====
`default_nettype none
package crc_pkg;

	// operation codes on func
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_DRAW  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BG     = 2'd2;

	// field widths
	localparam int FUNC_W  = 2;
	localparam int COORD_W = 18;
	localparam int RAD_W   = 17;
	localparam int CHAR_W  = 7;
	localparam int RDPOS_W = 8;
	localparam int DIM_W   = 9;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 9;

	// register reset values
	localparam logic [DIM_W-1:0]  RST_WIDTH  = 9'd256;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 9'd256;
	localparam logic [CHAR_W-1:0] RST_BG     = 7'd32;

	// parameter defaults
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 8;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic draw;
		logic setup_beat;
		logic cell_beat;
		logic rd_beat;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic area_zero;
		logic last_cell;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/crc_ctrl.sv =====
`default_nettype none
module crc_ctrl
	import crc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FUNC_W-1:0] func,
	input  wire stat_t             stat,
	output logic                   busy,
	output cmd_t                   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DRN1 = 3'd3;
	localparam logic [2:0] ST_DRN2 = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// commands
	always_comb begin
		cmd            = '0;
		cmd.load       = accept && (func == FUNC_CLEAR || func == FUNC_DRAW);
		cmd.draw       = (func == FUNC_DRAW);
		cmd.rd_beat    = accept && (func == FUNC_READ);
		cmd.setup_beat = (state_q == ST_PREP);
		cmd.cell_beat  = (state_q == ST_SCAN);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !stat.area_zero) begin
					if (func == FUNC_CLEAR)
						state_nxt = ST_SCAN;
					else if (func == FUNC_DRAW)
						state_nxt = ST_PREP;
				end
			end
			ST_PREP: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat.last_cell)
					state_nxt = ST_DRN1;
			end
			ST_DRN1: state_nxt = ST_DRN2;
			ST_DRN2: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule
`default_nettype wire

// ===== src/crc_dp.sv =====
`default_nettype none
module crc_dp
	import crc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output stat_t                          stat,
	input  wire logic                      cfg_we,
	input  wire logic [CFGI_W-1:0]         cfg_idx,
	input  wire logic [CFGD_W-1:0]         cfg_data,
	input  wire logic signed [COORD_W-1:0] center_x,
	input  wire logic signed [COORD_W-1:0] center_y,
	input  wire logic [RAD_W-1:0]          circle_radius,
	input  wire logic                      filled,
	input  wire logic [CHAR_W-1:0]         paint_char,
	input  wire logic [RDPOS_W-1:0]        read_col,
	input  wire logic [RDPOS_W-1:0]        read_row,
	output logic                           cell_valid,
	output logic [CHAR_W-1:0]              cell_char
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = ((CW > RW) ? CW : RW) + FRAC_BITS;
	localparam int DW    = ((XW > COORD_W) ? XW : COORD_W) + 2;
	localparam int PW    = 2 * DW;

	// configuration registers
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [CHAR_W-1:0] bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			bg_q     <= RST_BG;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_BG:     bg_q     <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// active area, saturated to storage
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;

	assign eff_w = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;

	// item operands
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RAD_W-1:0]          rad_q;
	logic                      fill_q;
	logic [CHAR_W-1:0]         paint_q;
	logic                      clr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			rad_q   <= circle_radius;
			fill_q  <= filled;
			paint_q <= paint_char;
			clr_q   <= !cmd.draw;
		end
	end

	// cell scan counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col;
	logic          last_row;

	assign last_col = (32'(col_q) + 1 == 32'(eff_w));
	assign last_row = (32'(row_q) + 1 == 32'(eff_h));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.cell_beat) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign stat.area_zero = (eff_w == '0) || (eff_h == '0);
	assign stat.last_cell = last_col && last_row;

	// stage 1: offsets from the centre, or radius and inner radius on setup
	logic signed [DW-1:0] unit;
	logic signed [DW-1:0] rad_ext;
	logic signed [DW-1:0] col_fx;
	logic signed [DW-1:0] row_fx;
	logic [AW-1:0]        cell_addr;

	assign unit      = DW'(1) <<< FRAC_BITS;
	assign rad_ext   = DW'(rad_q);
	assign col_fx    = DW'(col_q) <<< FRAC_BITS;
	assign row_fx    = DW'(row_q) <<< FRAC_BITS;
	assign cell_addr = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));

	logic                 valid_s1;
	logic                 setup_s1;
	logic signed [DW-1:0] opa_s1;
	logic signed [DW-1:0] opb_s1;
	logic [AW-1:0]        addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			setup_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.setup_beat || cmd.cell_beat;
			setup_s1 <= cmd.setup_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup_beat) begin
			opa_s1 <= rad_ext;
			opb_s1 <= rad_ext - unit;
		end else begin
			opa_s1 <= col_fx - DW'(cx_q);
			opb_s1 <= row_fx - DW'(cy_q);
		end
		addr_s1 <= cell_addr;
	end

	// stage 2: squares
	logic                 valid_s2;
	logic                 setup_s2;
	logic signed [PW-1:0] pa_s2;
	logic signed [PW-1:0] pb_s2;
	logic [AW-1:0]        addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			setup_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			setup_s2 <= setup_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s2   <= opa_s1 * opa_s1;
		pb_s2   <= opb_s1 * opb_s1;
		addr_s2 <= addr_s1;
	end

	// squared radii, taken from the setup beat
	logic signed [PW-1:0] r2_q;
	logic signed [PW-1:0] r12_q;
	logic                 r1neg_q;

	always_ff @(posedge clk) begin
		if (valid_s2 && setup_s2) begin
			r2_q  <= pa_s2;
			r12_q <= pb_s2;
		end
		if (cmd.load)
			r1neg_q <= ($signed(DW'(circle_radius)) < unit);
	end

	// stage 3: disc and outline band test, cell write
	logic signed [PW:0] d2;
	logic               hit;
	logic               band;
	logic               wr_en;
	logic [CHAR_W-1:0]  wr_data;

	assign d2      = (PW+1)'(pa_s2) + (PW+1)'(pb_s2);
	assign hit     = (d2 <= (PW+1)'(r2_q));
	assign band    = r1neg_q || (d2 > (PW+1)'(r12_q));
	assign wr_en   = valid_s2 && !setup_s2 && (clr_q || (hit && (fill_q || band)));
	assign wr_data = clr_q ? bg_q : paint_q;

	// canvas memory
	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              rd_oob;
	logic              rd_oob_q;

	assign rd_addr = AW'(32'(read_row) * MAX_WIDTH + 32'(read_col));
	assign rd_oob  = (32'(read_col) >= MAX_WIDTH) || (32'(read_row) >= MAX_HEIGHT);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s2] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_beat) begin
			rd_data_q <= mem[rd_addr];
			rd_oob_q  <= rd_oob;
		end
	end

	// result beat
	logic rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_valid_q <= 1'b0;
		else
			rd_valid_q <= cmd.rd_beat;
	end

	assign cell_valid = rd_valid_q;
	assign cell_char  = rd_oob_q ? bg_q : rd_data_q;

endmodule
`default_nettype wire

// ===== src/circle_raster_canvas.sv =====
// channel   signals                                             handshake
// -------   -------------------------------------------------   ------------------------
// command   func center_x center_y circle_radius filled         start high, busy low
//           paint_char read_col read_row
// result    cell_char                                           cell_valid, one cycle
// config    cfg_idx cfg_data                                    cfg_we, taken at once
//
// read: busy stays low; cell_char shows on the cycle after the beat.
// clear: busy through the scan of the W*H active cells and the drain states
// DRN1 and DRN2; draw adds the setup state PREP first. W and H are the active
// width and height; the scan writes one cell per cycle via one memory write port.
// reset clears the controller, config registers and valid bits, not canvas memory.
// results cannot be stalled by the receiver.
`default_nettype none
module circle_raster_canvas
	import crc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [FUNC_W-1:0]         func,
	input  wire logic signed [COORD_W-1:0] center_x,
	input  wire logic signed [COORD_W-1:0] center_y,
	input  wire logic [RAD_W-1:0]          circle_radius,
	input  wire logic                      filled,
	input  wire logic [CHAR_W-1:0]         paint_char,
	input  wire logic [RDPOS_W-1:0]        read_col,
	input  wire logic [RDPOS_W-1:0]        read_row,
	output logic                           cell_valid,
	output logic [CHAR_W-1:0]              cell_char,
	input  wire logic                      cfg_we,
	input  wire logic [CFGI_W-1:0]         cfg_idx,
	input  wire logic [CFGD_W-1:0]         cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	crc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// scan, circle test and canvas
	crc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.center_x      (center_x),
		.center_y      (center_y),
		.circle_radius (circle_radius),
		.filled        (filled),
		.paint_char    (paint_char),
		.read_col      (read_col),
		.read_row      (read_row),
		.cell_valid    (cell_valid),
		.cell_char     (cell_char)
	);

endmodule
`default_nettype wire
